### rtl/motor_fast_fault_detector_top_macros.svh
// Assertion macros for the motor fast fault detector checker.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef MOTOR_FAST_FAULT_DETECTOR_TOP_MACROS_SVH
`define MOTOR_FAST_FAULT_DETECTOR_TOP_MACROS_SVH

// same-cycle implication
`define MFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mfd_pkg.sv
// Shared types and constants for the motor fast fault detector.
// No dependencies.
package mfd_pkg;

	localparam int CUR_W   = 16;
	localparam int VOLT_W  = 16;
	localparam int ENC_W   = 8;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;

	typedef logic [2:0] fault_t;

	localparam fault_t FAULT_CLEAR = 3'd0;
	localparam fault_t FAULT_OC    = 3'd1;
	localparam fault_t FAULT_OV    = 3'd2;
	localparam fault_t FAULT_UV    = 3'd3;
	localparam fault_t FAULT_ENC   = 3'd4;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_OC_LIMIT  = 3'd0;
	localparam cfg_idx_t REG_OV_LIMIT  = 3'd1;
	localparam cfg_idx_t REG_UV_LIMIT  = 3'd2;
	localparam cfg_idx_t REG_CONFIRM   = 3'd3;
	localparam cfg_idx_t REG_ENC_LIMIT = 3'd4;

	typedef struct packed {
		logic signed [CUR_W-1:0] current_u;
		logic signed [CUR_W-1:0] current_v;
		logic signed [CUR_W-1:0] current_w;
		logic [VOLT_W-1:0]       bus_voltage;
		logic [ENC_W-1:0]        encoder_errors;
	} sample_t;

endpackage

### rtl/motor_fast_fault_detector_top.sv
// Path: a sample is held in the input register, evaluated, and its fault word held in the result register until taken.
// Throughput: one sample word per cycle while sample_stall is low; evaluation is a single pass of compares
// and saturating counter increments between the input register and the result register.
// Reset (arst_n low, async): pipeline empty, voltage counters zero, limits at
// their defaults (oc 32768, ov 65535, uv 0, confirm 20, encoder 255).
// Depends on mfd_pkg.
module motor_fast_fault_detector_top #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  mfd_pkg::cfg_idx_t                  cfg_index,
	input  logic [mfd_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic signed [mfd_pkg::CUR_W-1:0]   current_u,
	input  logic signed [mfd_pkg::CUR_W-1:0]   current_v,
	input  logic signed [mfd_pkg::CUR_W-1:0]   current_w,
	input  logic [mfd_pkg::VOLT_W-1:0]         bus_voltage,
	input  logic [mfd_pkg::ENC_W-1:0]          encoder_errors,
	output logic                               fault_valid,
	input  logic                               fault_stall,
	output mfd_pkg::fault_t                    fault_code
);
	import mfd_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	logic [CFG_W-1:0] oc_limit_q;
	logic [CFG_W-1:0] ov_limit_q;
	logic [CFG_W-1:0] uv_limit_q;
	logic [CFG_W-1:0] confirm_q;
	logic [ENC_W-1:0] enc_limit_q;

	logic [COUNT_WIDTH-1:0] ov_count_q;
	logic [COUNT_WIDTH-1:0] uv_count_q;

	sample_t smp_s1;
	logic    valid_s1;
	fault_t  code_s2;
	logic    valid_s2;

	logic s2_ready;
	logic s1_move;

	logic [CUR_W:0] mag_u, mag_v, mag_w;
	logic oc_hit, ov_out, uv_out, ov_hit, uv_hit, enc_hit;
	logic [COUNT_WIDTH-1:0] ov_next, uv_next;
	fault_t code_c;

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_limit_q  <= 16'd32768;
			ov_limit_q  <= 16'd65535;
			uv_limit_q  <= 16'd0;
			confirm_q   <= 16'd20;
			enc_limit_q <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OC_LIMIT:  oc_limit_q  <= cfg_wdata;
				REG_OV_LIMIT:  ov_limit_q  <= cfg_wdata;
				REG_UV_LIMIT:  uv_limit_q  <= cfg_wdata;
				REG_CONFIRM:   confirm_q   <= cfg_wdata;
				REG_ENC_LIMIT: enc_limit_q <= cfg_wdata[ENC_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control
	assign s2_ready     = !valid_s2 || !fault_stall;
	assign s1_move      = valid_s1 && s2_ready;
	assign sample_stall = valid_s1 && !s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			smp_s1.current_u      <= current_u;
			smp_s1.current_v      <= current_v;
			smp_s1.current_w      <= current_w;
			smp_s1.bus_voltage    <= bus_voltage;
			smp_s1.encoder_errors <= encoder_errors;
		end
	end

	// exact 17-bit magnitude, so -32768 gives 32768
	function automatic logic [CUR_W:0] mag17(input logic signed [CUR_W-1:0] x);
		logic [CUR_W:0] sx;
		sx = {x[CUR_W-1], x};
		return x[CUR_W-1] ? (~sx + 1'b1) : sx;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_up(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	always_comb begin
		mag_u  = mag17(smp_s1.current_u);
		mag_v  = mag17(smp_s1.current_v);
		mag_w  = mag17(smp_s1.current_w);
		oc_hit = (mag_u > {1'b0, oc_limit_q}) || (mag_v > {1'b0, oc_limit_q}) ||
			(mag_w > {1'b0, oc_limit_q});

		ov_out  = smp_s1.bus_voltage > ov_limit_q;
		uv_out  = smp_s1.bus_voltage < uv_limit_q;
		ov_next = ov_out ? sat_up(ov_count_q) : '0;
		uv_next = uv_out ? sat_up(uv_count_q) : '0;
		ov_hit  = ov_out && (CMP_W'(ov_next) >= CMP_W'(confirm_q));
		uv_hit  = uv_out && (CMP_W'(uv_next) >= CMP_W'(confirm_q));
		enc_hit = smp_s1.encoder_errors >= enc_limit_q;

		priority if (oc_hit) begin
			code_c = FAULT_OC;
		end else if (ov_hit) begin
			code_c = FAULT_OV;
		end else if (uv_hit) begin
			code_c = FAULT_UV;
		end else if (enc_hit) begin
			code_c = FAULT_ENC;
		end else begin
			code_c = FAULT_CLEAR;
		end
	end

	// overcurrent leaves both counters; overvoltage confirm skips the uv update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_count_q <= '0;
			uv_count_q <= '0;
		end else if (s1_move && !oc_hit) begin
			ov_count_q <= ov_next;
			if (!ov_hit) begin
				uv_count_q <= uv_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			code_s2 <= code_c;
		end
	end

	assign fault_valid = valid_s2;
	assign fault_code  = code_s2;

endmodule

### rtl/mfd_checker.sv
// Port-level checker for motor_fast_fault_detector_top, bound to the top level.
// Depends on mfd_pkg and motor_fast_fault_detector_top_macros.svh.
`include "motor_fast_fault_detector_top_macros.svh"

module mfd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            sample_valid,
	input logic            sample_stall,
	input logic            fault_valid,
	input logic            fault_stall,
	input mfd_pkg::fault_t fault_code
);
	import mfd_pkg::*;

	// a held result word keeps its code
	`MFD_ASSERT_NEXT(a_hold, fault_valid && fault_stall, fault_valid && $stable(fault_code), "fault word changed while stalled")

	`MFD_ASSERT_NOW(a_code_range, fault_valid, fault_code <= FAULT_ENC, "fault code out of range")

	// input backs up only when the result register is full and stalled
	`MFD_ASSERT_NOW(a_stall_cause, sample_stall, fault_valid && fault_stall, "sample stall with free result register")

	// result taken with no new sample leaves the input free next cycle
	`MFD_ASSERT_NEXT(a_drain, fault_valid && !fault_stall && !sample_valid, !sample_stall, "input stall after drain")

endmodule

bind motor_fast_fault_detector_top mfd_checker u_mfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.fault_valid  (fault_valid),
	.fault_stall  (fault_stall),
	.fault_code   (fault_code)
);
